[src/pareto_archive_update_assert.svh]
`ifndef PARETO_ARCHIVE_UPDATE_ASSERT_SVH
`define PARETO_ARCHIVE_UPDATE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PAU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pareto archive check failed");

// next-cycle implication, checked outside reset
`define PAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pareto archive check failed");

`endif

[src/pau_pkg.sv]
package pau_pkg;

  localparam int OBJ_FIELD_W   = 16;
  localparam int TAG_W         = 32;
  localparam int COUNT_FIELD_W = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONVERGE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SIZE   = 1'b1;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [OBJ_FIELD_W-1:0] objective_a;
    logic [OBJ_FIELD_W-1:0] objective_b;
    logic [TAG_W-1:0]       solution_tag;
  } in_t;

  typedef struct packed {
    logic                     added;
    logic [COUNT_FIELD_W-1:0] removed_count;
    logic [COUNT_FIELD_W-1:0] archive_count;
    logic                     overflow;
    logic                     optimum_found;
  } out_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_STORE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic wipe_en;
    logic store;
    logic clear_state;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

[src/pau_ctrl.sv]
module pau_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             opcode,
  output logic             in_ready,
  input  pau_pkg::status_t status,
  output pau_pkg::cmd_t    cmd
);

  pau_pkg::state_t state, state_next;
  logic report, report_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pau_pkg::ST_WIPE;
      report <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
    end
  end

  always_comb begin
    state_next  = state;
    report_next = report;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      pau_pkg::ST_WIPE: begin
        cmd.wipe_en = 1'b1;
        if (status.idx_last) begin
          cmd.clear_state = 1'b1;
          state_next = report ? pau_pkg::ST_FINISH : pau_pkg::ST_IDLE;
        end
      end
      pau_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (opcode == pau_pkg::OP_CLEAR) begin
            state_next  = pau_pkg::ST_WIPE;
            report_next = 1'b1;
          end else begin
            state_next = pau_pkg::ST_SCAN;
          end
        end
      end
      pau_pkg::ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (status.idx_last) begin
          state_next = pau_pkg::ST_DRAIN;
        end
      end
      pau_pkg::ST_DRAIN: begin
        state_next = pau_pkg::ST_STORE;
      end
      pau_pkg::ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = pau_pkg::ST_FINISH;
      end
      pau_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          report_next = 1'b0;
          state_next  = pau_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pau_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/pau_dp.sv]
module pau_dp #(
  parameter int ARCHIVE_DEPTH   = 64,
  parameter int OBJECTIVE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pau_pkg::in_t                      in_data,
  input  pau_pkg::cmd_t                     cmd,
  output pau_pkg::status_t                  status,
  input  logic                              cfg_we,
  input  logic [pau_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pau_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pau_pkg::out_t                     out_data
);

  localparam int AW = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
  localparam int CW = $clog2(ARCHIVE_DEPTH + 1);
  localparam int OW = OBJECTIVE_WIDTH;
  localparam int MW = 1 + 2 * OW + pau_pkg::TAG_W;
  localparam int EW = (CW > pau_pkg::COUNT_FIELD_W) ? CW : pau_pkg::COUNT_FIELD_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(ARCHIVE_DEPTH - 1);

  // entry word: {tag, b, a, valid}
  logic [MW-1:0] mem [ARCHIVE_DEPTH];

  logic [OW-1:0]             cand_a, cand_b;
  logic [pau_pkg::TAG_W-1:0] cand_tag;
  logic [AW-1:0]             idx;
  logic [MW-1:0]             rd_q;
  logic                      chk_v;
  logic [AW-1:0]             chk_addr;
  logic                      rej, free_found, added, over;
  logic [AW-1:0]             free_addr;
  logic [CW-1:0]             removed, count, count_plus;
  logic                      flag;
  logic                      converge_mode;
  logic [pau_pkg::CFG_DATA_W-1:0] target_size;

  logic          e_valid;
  logic [OW-1:0] ea, eb;
  logic          cand_beats, ent_blocks, kill, store_ok;
  logic          we;
  logic [AW-1:0] wa;
  logic [MW-1:0] wd;

  assign status.idx_last = (idx == LAST_IDX);
  assign status.out_free = !out_valid || out_ready;

  assign e_valid    = rd_q[0];
  assign ea         = rd_q[OW:1];
  assign eb         = rd_q[2*OW:OW+1];
  assign cand_beats = (cand_a >= ea) && (cand_b >= eb) && ((cand_a > ea) || (cand_b > eb));
  assign ent_blocks = (ea >= cand_a) && (eb >= cand_b);
  assign kill       = chk_v && e_valid && cand_beats;
  assign store_ok   = !rej && free_found;
  assign count_plus = count + 1'b1;

  always_comb begin
    we = 1'b0;
    wa = idx;
    wd = '0;
    if (cmd.wipe_en) begin
      we = 1'b1;
    end else if (kill) begin
      we = 1'b1;
      wa = chk_addr;
    end else if (cmd.store && store_ok) begin
      we = 1'b1;
      wa = free_addr;
      wd = {cand_tag, cand_b, cand_a, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_a   <= OW'(in_data.objective_a);
      cand_b   <= OW'(in_data.objective_b);
      cand_tag <= in_data.solution_tag;
    end
    chk_addr <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      chk_v      <= 1'b0;
      rej        <= 1'b0;
      free_found <= 1'b0;
      free_addr  <= '0;
      removed    <= '0;
      added      <= 1'b0;
      over       <= 1'b0;
      count      <= '0;
      flag       <= 1'b0;
    end else begin
      chk_v <= cmd.rd_en;
      if (cmd.rd_en || cmd.wipe_en) begin
        idx <= status.idx_last ? '0 : idx + 1'b1;
      end
      if (cmd.load) begin
        rej        <= 1'b0;
        free_found <= 1'b0;
        removed    <= '0;
        added      <= 1'b0;
        over       <= 1'b0;
      end
      if (chk_v) begin
        if (e_valid && ent_blocks) begin
          rej <= 1'b1;
        end
        if (!free_found && (!e_valid || kill)) begin
          free_found <= 1'b1;
          free_addr  <= chk_addr;
        end
      end
      if (kill) begin
        removed <= removed + 1'b1;
        count   <= count - 1'b1;
      end
      if (cmd.store) begin
        added <= store_ok;
        over  <= !rej && !free_found;
        if (store_ok) begin
          count <= count_plus;
          if (converge_mode && (EW'(count_plus) == EW'(target_size))) begin
            flag <= 1'b1;
          end
        end
      end
      if (cmd.clear_state) begin
        count <= '0;
        flag  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      converge_mode <= 1'b0;
      target_size   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pau_pkg::CFG_CONVERGE_MODE: converge_mode <= cfg_data[0];
        pau_pkg::CFG_TARGET_SIZE:   target_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.added         <= added;
      out_data.removed_count <= pau_pkg::COUNT_FIELD_W'(removed);
      out_data.archive_count <= pau_pkg::COUNT_FIELD_W'(count);
      out_data.overflow      <= over;
      out_data.optimum_found <= flag;
    end
  end

endmodule

[src/pareto_archive_update.sv]
// insert: the input beat is taken in idle, then the single-read scan walks the entry memory,
//   one entry per cycle, and the drain, store and finish states give the result; the next
//   input beat is taken once the result is emitted; a held result adds its wait
// clear: the entry memory is swept invalid, then the result is emitted and the next beat taken
// reset: synchronous; afterwards the entry memory is swept invalid with
//   in_ready low; config writes are taken throughout
module pareto_archive_update #(
  parameter int ARCHIVE_DEPTH   = 64,
  parameter int OBJECTIVE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pau_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pau_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [pau_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pau_pkg::CFG_DATA_W-1:0] cfg_data
);

  // controller sequences the sweep: wipe, idle, scan, drain, store, finish
  // datapath holds the entry memory, candidate, counters and result register
  pau_pkg::cmd_t    cmd;
  pau_pkg::status_t status;

  // fsm only sees the opcode of the input beat
  pau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (in_data.opcode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // entries dominated by the candidate are invalidated during the scan; a
  // stored entry dominating or equal to the candidate rejects it (both cannot
  // happen together, since the archive stays mutually non-dominated)
  // the lowest slot that is free after removals gets the candidate
  pau_dp #(
    .ARCHIVE_DEPTH   (ARCHIVE_DEPTH),
    .OBJECTIVE_WIDTH (OBJECTIVE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[src/pau_checker.sv]
`include "pareto_archive_update_assert.svh"

module pau_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input pau_pkg::out_t out_data
);

  // a stalled result beat holds
  `PAU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // stored and dropped are exclusive
  `PAU_ASSERT_NOW(a_added_no_over, clk, rst, out_valid && out_data.added, !out_data.overflow)

  // a drop only happens when nothing was removed and nothing stored
  `PAU_ASSERT_NOW(a_over_clean, clk, rst, out_valid && out_data.overflow, !out_data.added && (out_data.removed_count == '0))

  // one item at a time: an input beat closes the input side in the next cycle
  `PAU_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind pareto_archive_update pau_checker u_pau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
